// ----- src/kst_pkg.sv -----
// ----------------------------------------------------------------------------
// kst_pkg
// Types and constants shared by the count tree with k-th unit selection.
// ----------------------------------------------------------------------------
package kst_pkg;

    localparam int SLOT_BITS  = 12;
    localparam int SLOT_COUNT = 1 << SLOT_BITS;
    localparam int NODE_BITS  = SLOT_BITS + 1;
    localparam int NODE_COUNT = 1 << NODE_BITS;
    localparam int CNT_W      = 32;

    localparam logic ACT_SELECT = 1'b0;
    localparam logic ACT_ADD    = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_NEGATIVE = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic                    action;
        logic [SLOT_BITS-1:0]    position;
        logic [CNT_W-1:0]        rank;
        logic signed [CNT_W-1:0] amount;
    } req_t;

    typedef struct packed {
        logic [SLOT_BITS-1:0] found_slot;
        logic [1:0]           status;
    } rsp_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_DESCEND,
        S_WRITE,
        S_DONE
    } state_t;

endpackage

// ----- src/kst_ram.sv -----
// ----------------------------------------------------------------------------
// kst_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module kst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // registered read, returns the old data on a write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- src/kth_select_count_tree.sv -----
// ----------------------------------------------------------------------------
// kth_select_count_tree
// Segment tree of subtree counts in one RAM; add to a slot or select the
// slot of the k-th unit and remove it.
// ----------------------------------------------------------------------------
// throughput: one transaction at a time; busy stays high through the strobe and
//   drops in the cycle after it.
// reset: a clearing pass zeroes all 8192 nodes of the tree RAM, busy high.
// the receiver cannot stall; each result shows for exactly one cycle.
module kth_select_count_tree
    import kst_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t rsp
);

    state_t state_reg, state_next;
    logic [NODE_BITS-1:0] addr_reg, addr_next;   // current node; 1 = root
    logic [3:0]           lvl_reg, lvl_next;     // levels remaining below node
    logic [1:0]           ph_reg, ph_next;       // step phase within a level
    req_t                 req_reg, req_next;
    logic [CNT_W-1:0]     r_reg, r_next;
    logic [CNT_W-1:0]     delta_reg, delta_next;
    logic [CNT_W-1:0]     total_reg, total_next;
    logic [1:0]           st_reg, st_next;

    logic                 we;
    logic [NODE_BITS-1:0] ram_addr;
    logic [CNT_W-1:0]     wdata, rdata;

    kst_ram #(.WIDTH(CNT_W), .DEPTH(NODE_COUNT)) u_ram (
        .clk(clk), .we(we), .addr(ram_addr), .wdata(wdata), .rdata(rdata)
    );

    logic [CNT_W:0] leaf_sum, tot_sum;
    logic           bit_sel;
    assign leaf_sum = {1'b0, rdata} + {req_reg.amount[CNT_W-1], req_reg.amount};
    assign tot_sum  = {1'b0, total_reg} + {req_reg.amount[CNT_W-1], req_reg.amount};
    // position bit steering the descent to the child of this node
    assign bit_sel  = 1'(req_reg.position >> (lvl_reg - 1'b1));

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            addr_reg  <= '0;
            lvl_reg   <= '0;
            ph_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            lvl_reg   <= lvl_next;
            ph_reg    <= ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        r_reg     <= r_next;
        delta_reg <= delta_next;
        total_reg <= total_next;
        st_reg    <= st_next;
    end

    // next state and datapath
    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        lvl_next   = lvl_reg;
        ph_next    = ph_reg;
        req_next   = req_reg;
        r_next     = r_reg;
        delta_next = delta_reg;
        total_next = total_reg;
        st_next    = st_reg;
        case (state_reg)
            S_CLEAR:
            begin
                addr_next = addr_reg + 1'b1;
                if (addr_reg == NODE_BITS'(NODE_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                addr_next = NODE_BITS'(1);
                ph_next   = '0;
                if (start)
                begin
                    req_next   = req;
                    st_next    = ST_OK;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // ph 0: root read issued; ph 1: root data; ph 3: leaf read issued; ph 2: leaf data
                lvl_next = 4'(SLOT_BITS);
                r_next   = req_reg.rank;
                if (ph_reg == 2'd0)
                begin
                    ph_next = 2'd1;
                end
                else if (ph_reg == 2'd1)
                begin
                    total_next = rdata;
                    if (req_reg.action == ACT_SELECT)
                    begin
                        delta_next = '1;
                        ph_next    = '0;
                        if (req_reg.rank == '0 || req_reg.rank > rdata)
                        begin
                            st_next    = ST_RANGE;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_DESCEND;
                        end
                    end
                    else
                    begin
                        addr_next = NODE_BITS'({1'b1, req_reg.position});
                        ph_next   = 2'd3;
                    end
                end
                else if (ph_reg == 2'd3)
                begin
                    ph_next = 2'd2;
                end
                else
                begin
                    delta_next = req_reg.amount;
                    addr_next  = NODE_BITS'(1);
                    ph_next    = '0;
                    // a slot can only go below zero on a negative amount
                    if (req_reg.amount[CNT_W-1] && leaf_sum[CNT_W])
                    begin
                        st_next    = ST_NEGATIVE;
                        state_next = S_DONE;
                    end
                    else if (tot_sum[CNT_W])
                    begin
                        st_next    = ST_OVERFLOW;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
            end
            S_DESCEND:
            begin
                // read left child, wait, then choose side
                if (ph_reg == 2'd0)
                begin
                    ph_next = 2'd1;
                end
                else if (ph_reg == 2'd1)
                begin
                    ph_next = 2'd2;
                end
                else
                begin
                    ph_next  = '0;
                    lvl_next = lvl_reg - 1'b1;
                    if (r_reg <= rdata)
                    begin
                        addr_next = {addr_reg[NODE_BITS-2:0], 1'b0};
                    end
                    else
                    begin
                        r_next    = r_reg - rdata;
                        addr_next = {addr_reg[NODE_BITS-2:0], 1'b1};
                    end
                    if (lvl_reg == 4'd1)
                    begin
                        req_next.position = r_reg <= rdata
                            ? addr_reg[SLOT_BITS-1:0] << 1
                            : (addr_reg[SLOT_BITS-1:0] << 1) | SLOT_BITS'(1);
                        addr_next  = NODE_BITS'(1);
                        lvl_next   = 4'(SLOT_BITS);
                        state_next = S_WRITE;
                    end
                end
            end
            S_WRITE:
            begin
                // ph 0 read, ph 1 wait, ph 2 write and step down
                if (ph_reg == 2'd0)
                begin
                    ph_next = 2'd1;
                end
                else if (ph_reg == 2'd1)
                begin
                    ph_next = 2'd2;
                end
                else
                begin
                    ph_next   = '0;
                    lvl_next  = lvl_reg - 1'b1;
                    addr_next = {addr_reg[NODE_BITS-2:0], bit_sel};
                    if (lvl_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // left child is read during descent
    end

    // memory port and outputs
    always_comb
    begin
        we       = 1'b0;
        ram_addr = addr_reg;
        wdata    = '0;
        busy     = 1'b1;
        done     = 1'b0;
        rsp      = '0;
        case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
            end
            S_IDLE:
            begin
                busy = 1'b0;
            end
            S_DESCEND:
            begin
                ram_addr = {addr_reg[NODE_BITS-2:0], 1'b0};
            end
            S_WRITE:
            begin
                if (ph_reg == 2'd2)
                begin
                    we    = 1'b1;
                    wdata = rdata + delta_reg;
                end
            end
            S_DONE:
            begin
                done = 1'b1;
                rsp.status = st_reg;
                if (st_reg == ST_OK && req_reg.action == ACT_SELECT)
                begin
                    rsp.found_slot = req_reg.position;
                end
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// ----- sim/kth_select_count_tree_test.sv -----
// ----------------------------------------------------------------------------
// kth_select_count_tree_test
// Drives add and select transactions into the count tree, keeps its own copy
// of the per-slot counts, predicts slot and status, and checks each strobe.
// ----------------------------------------------------------------------------
module kth_select_count_tree_test;
    import kst_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 40000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t rsp;

    // model state: per-slot counts and the total
    logic [31:0] slot_counts [SLOT_COUNT];
    logic [31:0] total_count;
    rsp_t        pending_rsp [$];
    int          fail_count;
    int          idle_cycles;
    bit          gaps_on;

    kth_select_count_tree u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // expected result of one transaction, updating the model counts
    function automatic rsp_t predict_tree(req_t r);
        rsp_t        res;
        logic [31:0] left_rank;
        longint      leaf_new;
        longint      total_new;
        res = '0;
        if (r.action == ACT_ADD) begin
            leaf_new  = longint'(slot_counts[r.position]) + longint'(r.amount);
            total_new = longint'(total_count) + longint'(r.amount);
            if (leaf_new < 0)
                res.status = ST_NEGATIVE;
            else if (total_new > 64'hFFFF_FFFF)
                res.status = ST_OVERFLOW;
            else
            begin
                slot_counts[r.position] = leaf_new[31:0];
                total_count = total_new[31:0];
            end
        end
        else if (r.rank == 0 || r.rank > total_count) begin
            res.status = ST_RANGE;
        end
        else
        begin
            left_rank = r.rank;
            for (int s = 0; s < SLOT_COUNT; s++) begin
                if (left_rank <= slot_counts[s]) begin
                    res.found_slot = s[SLOT_BITS-1:0];
                    slot_counts[s] = slot_counts[s] - 1;
                    total_count = total_count - 1;
                    break;
                end
                left_rank = left_rank - slot_counts[s];
            end
        end
        return res;
    endfunction

    // send one transaction, with an optional random gap first
    task automatic send_item(req_t r);
        int gap;
        @(posedge clk);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy);
        pending_rsp.push_back(predict_tree(r));
        start <= 1'b0;
    endtask

    task automatic send_add(int pos, int amt);
        req_t r;
        r = '0;
        r.action   = ACT_ADD;
        r.position = pos[SLOT_BITS-1:0];
        r.amount   = amt;
        r.rank     = $urandom();
        send_item(r);
    endtask

    task automatic send_select(logic [31:0] rk);
        req_t r;
        r = '0;
        r.action   = ACT_SELECT;
        r.rank     = rk;
        r.position = $urandom();
        r.amount   = $urandom();
        send_item(r);
    endtask

    task automatic wait_drained();
        while (pending_rsp.size() != 0) @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && done) begin
            if (pending_rsp.size() == 0) begin
                $error("unexpected result slot=%0d status=%0d", rsp.found_slot, rsp.status);
                fail_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.found_slot !== want.found_slot) begin
                    $error("found_slot expected %0d actual %0d", want.found_slot,
                           rsp.found_slot);
                    fail_count++;
                end
                if (rsp.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, rsp.status);
                    fail_count++;
                end
            end
        end
    end

    // watchdog, allows for the clearing pass after reset
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("kth_select_count_tree verification failed");
            $finish;
        end
    end

    // field extremes, status codes and empty-tree selects
    task automatic test_directed();
        send_select(32'd0);
        send_select(32'd1);
        send_select(32'hFFFF_FFFF);
        send_add(0, -1);
        send_add(4095, 5);
        send_add(0, 3);
        send_add(2048, 32'sh7FFF_FFFF);
        send_add(100, 32'sh7FFF_FFFF);
        send_add(7, 2);
        send_add(4095, -6);
        send_add(4095, 0);
        send_select(32'd0);
        send_select(32'd1);
        send_select(total_count);
        send_select(total_count + 1);
        send_select(32'd4);
        send_add(2048, 32'sh8000_0001);
        send_add(100, 32'sh8000_0000);
        send_add(2048, -2);
        send_add(100, -32'sh7FFF_FFFF);
        send_select(32'd1);
        send_select(32'd1);
        send_add(3, 32'sh8000_0000);
        send_select(32'hFFFF_FFFF);
    endtask

    // pause until the tree has answered everything
    task automatic test_drain_pause();
        wait_drained();
        repeat (50) @(posedge clk);
    endtask

    // mostly valid adds and selects over a few hot slots, with noise
    task automatic test_random(int n);
        int pick;
        int pos;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                               : $urandom_range(0, 15) * 273;
            if (pick < 35)
                send_add(pos, $urandom_range(1, 20));
            else if (pick < 42)
                send_add(pos, -int'($urandom_range(0, 25)));
            else if (pick < 46)
                send_add(pos, int'($urandom()));
            else if (pick < 90)
                send_select((total_count == 0) ? 32'd1
                            : $urandom_range(1, total_count > 1000 ? 1000 : total_count));
            else if (pick < 95)
                send_select(total_count + $urandom_range(0, 3));
            else
                send_select($urandom());
        end
    endtask

    initial
    begin
        for (int s = 0; s < SLOT_COUNT; s++) slot_counts[s] = '0;
        total_count = '0;
        fail_count  = 0;
        idle_cycles = 0;
        gaps_on     = 1'b0;
        start = 1'b0;
        req   = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_drain_pause();
        gaps_on = 1'b1;
        test_random(1400);
        test_drain_pause();
        gaps_on = 1'b0;
        test_random(500);
        wait_drained();
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("kth_select_count_tree verification clean");
        else
            $display("kth_select_count_tree verification failed");
        $finish;
    end

endmodule
